// File: sv/binary_search_table_macros.svh
//==============================================================================
// Binary search table assertion macros
// Shared concurrent assertion forms for the binary search table block.
//==============================================================================
`ifndef BINARY_SEARCH_TABLE_MACROS_SVH
`define BINARY_SEARCH_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge outside reset.
`define BST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("binary search table assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define BST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binary search table implication failed");

`else

`define BST_ASSERT(lbl, clk, rst_n, prop)
`define BST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/bst_pkg.sv
//==============================================================================
// Binary search table package
// Operation codes, state encoding and default sizes for the block.
//==============================================================================
package bst_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_DATA_WIDTH  = 32;
    localparam int VALUE_WIDTH     = 32;
    localparam int POS_WIDTH       = 10;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP
    } state_t;

endpackage

// File: sv/bst_ram.sv
//==============================================================================
// Binary search table entry memory
// Simple dual-port synchronous memory with one write port and one registered
// read port.
//==============================================================================
module bst_ram #(
    parameter int DEPTH = bst_pkg::DEF_TABLE_DEPTH,
    parameter int WIDTH = bst_pkg::DEF_DATA_WIDTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/bst_ctrl.sv
//==============================================================================
// Binary search table controller
// Decodes commands, keeps the entry count and runs the halving search over
// the entry memory, each probe a read state followed by a compare state.
//==============================================================================
`include "binary_search_table_macros.svh"

module bst_ctrl #(
    parameter int TABLE_DEPTH = bst_pkg::DEF_TABLE_DEPTH,
    parameter int DATA_WIDTH  = bst_pkg::DEF_DATA_WIDTH,
    localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW         = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           mode,
    input  logic signed [bst_pkg::VALUE_WIDTH-1:0] value,
    output logic                                 done,
    output logic                                 found,
    output logic [bst_pkg::POS_WIDTH-1:0]        position,
    output logic                                 status,
    output logic                                 wr_en,
    output logic [AW-1:0]                        wr_addr,
    output logic [DATA_WIDTH-1:0]                wr_data,
    output logic                                 rd_en,
    output logic [AW-1:0]                        rd_addr,
    input  logic [DATA_WIDTH-1:0]                rd_data
);

    bst_pkg::state_t state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [AW-1:0]         mid_reg, mid_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic                  done_reg, done_next;
    logic                  found_reg, found_next;
    logic [bst_pkg::POS_WIDTH-1:0] position_reg, position_next;
    logic                  status_reg, status_next;

    logic                  accept;
    logic                  full;
    logic [63:0]           value_ext;
    logic [DATA_WIDTH-1:0] word;
    logic [CW:0]           range_sum;
    logic [AW-1:0]         mid;
    logic [CW-1:0]         mid_wide;
    logic                  key_less;

    assign accept    = start && !busy;
    assign full      = (count_reg == CW'(TABLE_DEPTH));
    assign value_ext = {{(64 - bst_pkg::VALUE_WIDTH){value[bst_pkg::VALUE_WIDTH-1]}}, value};
    assign word      = value_ext[DATA_WIDTH-1:0];
    assign range_sum = (CW + 1)'(lo_reg) + (CW + 1)'(hi_reg);
    assign mid       = AW'(range_sum >> 1);
    assign mid_wide  = CW'(mid_reg);
    assign key_less  = $signed(key_reg) < $signed(rd_data);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        key_next      = key_reg;
        done_next     = 1'b0;
        found_next    = 1'b0;
        position_next = '0;
        status_next   = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = AW'(count_reg);
        wr_data       = word;
        rd_en         = 1'b0;
        rd_addr       = mid;

        unique case (state_reg)
            bst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        bst_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        bst_pkg::MODE_APPEND:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                position_next = bst_pkg::POS_WIDTH'(count_reg);
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        bst_pkg::MODE_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = count_reg - 1'b1;
                                key_next   = word;
                                state_next = bst_pkg::ST_PROBE;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            bst_pkg::ST_PROBE:
            begin
                rd_en      = 1'b1;
                mid_next   = mid;
                state_next = bst_pkg::ST_CMP;
            end
            bst_pkg::ST_CMP:
            begin
                if (rd_data == key_reg)
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b1;
                    position_next = bst_pkg::POS_WIDTH'(mid_reg);
                    state_next    = bst_pkg::ST_IDLE;
                end
                else if (key_less)
                begin
                    if ((mid_reg == '0) || (lo_reg > mid_wide - 1'b1))
                    begin
                        done_next  = 1'b1;
                        state_next = bst_pkg::ST_IDLE;
                    end
                    else
                    begin
                        hi_next    = mid_wide - 1'b1;
                        state_next = bst_pkg::ST_PROBE;
                    end
                end
                else
                begin
                    if (mid_wide + 1'b1 > hi_reg)
                    begin
                        done_next  = 1'b1;
                        state_next = bst_pkg::ST_IDLE;
                    end
                    else
                    begin
                        lo_next    = mid_wide + 1'b1;
                        state_next = bst_pkg::ST_PROBE;
                    end
                end
            end
            default:
            begin
                state_next = bst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bst_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        key_reg      <= key_next;
        found_reg    <= found_next;
        position_reg <= position_next;
        status_reg   <= status_next;
    end

    assign busy     = (state_reg != bst_pkg::ST_IDLE);
    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;
    assign status   = status_reg;

    // The entry count never runs past the table depth.
    `BST_ASSERT(a_count_bounded, clk, rst_n, count_reg <= CW'(TABLE_DEPTH))
    // A search only runs on a non-empty table, inside the filled range.
    `BST_ASSERT_IMP(a_search_in_range, clk, rst_n, busy, (count_reg != '0) && (hi_reg < count_reg))
    // Each probe is issued only while the range is not empty.
    `BST_ASSERT_IMP(a_probe_range, clk, rst_n, state_reg == bst_pkg::ST_PROBE, lo_reg <= hi_reg)
    // A result never shows while a search is still running.
    `BST_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, state_reg == bst_pkg::ST_IDLE)
    // An append to a table with room gives a result and grows the count by one.
    `BST_ASSERT(a_append_grows, clk, rst_n, (accept && (mode == bst_pkg::MODE_APPEND) && !full) |=> (done_reg && !status_reg && (count_reg == $past(count_reg) + 1'b1)))

endmodule

// File: sv/binary_search_table.sv
//==============================================================================
// Binary search table
// Table of signed entries appended in order, with clear and halving search.
//==============================================================================
// A command is transferred when start is high and busy is low. Clear, append
// and an empty or no-operation command never raise busy: their result shows
// on done in the cycle after the transfer, and the next command may follow at
// once. A search raises busy and runs its probes one after another, each a
// read of the entry memory followed by a compare, so a table of n entries
// needs at most floor(log2 n) + 1 probes, 11 for 1024 entries; the result
// shows on done in the cycle after the last compare, while busy is already
// low. Each result is valid for that single cycle and cannot be stalled.
// The entry memory needs no clearing after reset; only the state, the entry
// count and done are reset.
//==============================================================================
module binary_search_table #(
    parameter int TABLE_DEPTH = bst_pkg::DEF_TABLE_DEPTH,
    parameter int DATA_WIDTH  = bst_pkg::DEF_DATA_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             mode,
    input  logic signed [bst_pkg::VALUE_WIDTH-1:0] value,
    output logic                                   done,
    output logic                                   found,
    output logic [bst_pkg::POS_WIDTH-1:0]          position,
    output logic                                   status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    bst_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .value    (value),
        .done     (done),
        .found    (found),
        .position (position),
        .status   (status),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    bst_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// File: bench/tb_binary_search_table.sv
//==============================================================================
// Binary search table testbench
// Drives clear, append, search and no-operation commands into the table and
// checks every result against a model of the table and its halving search,
// kept in a small scoreboard. Short directed sequences come first, then small
// random tables with random searches, then a table filled to capacity.
//==============================================================================
module tb_binary_search_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS  = 1050;
    localparam int MIXED_ITEMS  = 40;
    localparam int QUIET_TAIL   = 150;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 30;
    localparam logic signed [bst_pkg::VALUE_WIDTH-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [bst_pkg::VALUE_WIDTH-1:0] MOST_POS = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                          found;
        logic [bst_pkg::POS_WIDTH-1:0] position;
        logic                          status;
    } outcome_t;

    class search_table_scoreboard;
        logic signed [bst_pkg::VALUE_WIDTH-1:0] slots [bst_pkg::DEF_TABLE_DEPTH];
        int       fill;
        outcome_t outcomes_due [$];
        int       failures;

        function new();
            fill     = 0;
            failures = 0;
        endfunction

        function void note_command(logic [1:0] m,
                                   logic signed [bst_pkg::VALUE_WIDTH-1:0] v);
            outcome_t o;
            int       lo;
            int       hi;
            int       mid;
            o = '0;
            case (m)
                bst_pkg::MODE_CLEAR: fill = 0;
                bst_pkg::MODE_APPEND:
                begin
                    if (fill >= bst_pkg::DEF_TABLE_DEPTH)
                    begin
                        o.status = 1'b1;
                    end
                    else
                    begin
                        slots[fill] = v;
                        o.position  = bst_pkg::POS_WIDTH'(fill);
                        fill++;
                    end
                end
                bst_pkg::MODE_SEARCH:
                begin
                    lo = 0;
                    hi = fill - 1;
                    while (lo <= hi && !o.found)
                    begin
                        mid = (lo + hi) / 2;
                        if (slots[mid] == v)
                        begin
                            o.found    = 1'b1;
                            o.position = bst_pkg::POS_WIDTH'(mid);
                        end
                        else if (v < slots[mid])
                        begin
                            hi = mid - 1;
                        end
                        else
                        begin
                            lo = mid + 1;
                        end
                    end
                end
                default: ;
            endcase
            outcomes_due.push_back(o);
        endfunction

        function void check_result(logic f, logic [bst_pkg::POS_WIDTH-1:0] p, logic s);
            outcome_t e;
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: result with none due: found=%b position=%0d status=%b",
                         $time, f, p, s);
                failures++;
                return;
            end
            e = outcomes_due.pop_front();
            if ({f, p, s} !== e)
            begin
                $display(
                    "%0t: expected found=%b pos=%0d status=%b, got found=%b pos=%0d status=%b",
                    $time, e.found, e.position, e.status, f, p, s);
                failures++;
            end
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction
    endclass

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   start = 1'b0;
    logic [1:0]                             mode = bst_pkg::MODE_NOP;
    logic signed [bst_pkg::VALUE_WIDTH-1:0] value = '0;
    logic                                   busy;
    logic                                   done;
    logic                                   found;
    logic [bst_pkg::POS_WIDTH-1:0]          position;
    logic                                   status;

    search_table_scoreboard                 sb;
    logic signed [bst_pkg::VALUE_WIDTH-1:0] contents [$];
    bit                                     gappy;
    bit                                     wide_keys;
    int                                     sent;
    int                                     quiet_cycles = 0;

    binary_search_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .value    (value),
        .done     (done),
        .found    (found),
        .position (position),
        .status   (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(found, position, status);
            if (start && !busy)
                sb.note_command(mode, value);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic idle(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
            mode  <= 2'($urandom);
            value <= $urandom;
            @(posedge clk);
        end
    endtask

    task automatic issue(input logic [1:0] m,
                         input logic signed [bst_pkg::VALUE_WIDTH-1:0] v);
        if (gappy && (sent < TOTAL_ITEMS - QUIET_TAIL) && $urandom_range(0, 3) == 0)
            idle($urandom_range(1, 4));
        @(negedge clk);
        start <= 1'b1;
        mode  <= m;
        value <= v;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sent++;
    endtask

    function automatic logic signed [bst_pkg::VALUE_WIDTH-1:0] random_word(bit wide);
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
        if (wide)
            return $urandom;
        return int'($urandom_range(0, 64)) - 32;
    endfunction

    task automatic clear_table();
        issue(bst_pkg::MODE_CLEAR, $urandom);
        contents.delete();
    endtask

    task automatic append_word(input logic signed [bst_pkg::VALUE_WIDTH-1:0] v);
        issue(bst_pkg::MODE_APPEND, v);
        if (contents.size() < bst_pkg::DEF_TABLE_DEPTH)
            contents.push_back(v);
    endtask

    task automatic append_run(input int count, input bit wide, input bit ordered);
        int words [$];
        for (int i = 0; i < count; i++)
            words.push_back(int'(random_word(wide)));
        if (ordered)
            words.sort();
        foreach (words[i])
            append_word(words[i]);
    endtask

    task automatic search_random();
        int                                     pick;
        logic signed [bst_pkg::VALUE_WIDTH-1:0] key;
        pick = $urandom_range(0, 19);
        if (contents.size() > 0 && pick < 12)
            key = contents[$urandom_range(0, contents.size() - 1)];
        else if (contents.size() > 0 && pick < 16)
            key = contents[$urandom_range(0, contents.size() - 1)]
                  + ($urandom_range(0, 1) ? 1 : -1);
        else
            key = random_word(wide_keys);
        issue(bst_pkg::MODE_SEARCH, key);
    endtask

    initial
    begin
        int count;
        sb    = new();
        sent  = 0;
        gappy = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue(bst_pkg::MODE_SEARCH, 0);
        append_word(MOST_NEG);
        append_word(-5);
        append_word(-5);
        append_word(0);
        append_word(7);
        append_word(MOST_POS);
        issue(bst_pkg::MODE_SEARCH, MOST_NEG);
        issue(bst_pkg::MODE_SEARCH, MOST_POS);
        issue(bst_pkg::MODE_SEARCH, -5);
        issue(bst_pkg::MODE_SEARCH, 0);
        issue(bst_pkg::MODE_SEARCH, MOST_NEG + 1);
        issue(bst_pkg::MODE_SEARCH, 3);
        issue(bst_pkg::MODE_SEARCH, MOST_POS - 1);
        issue(bst_pkg::MODE_NOP, $urandom);
        clear_table();
        issue(bst_pkg::MODE_SEARCH, 0);
        append_word(10);
        issue(bst_pkg::MODE_SEARCH, 5);
        issue(bst_pkg::MODE_SEARCH, 20);
        append_word(3);
        issue(bst_pkg::MODE_SEARCH, 3);
        issue(bst_pkg::MODE_NOP, $urandom);
        clear_table();

        while (sent < MIXED_ITEMS)
        begin
            gappy     = ($urandom_range(0, 2) != 0);
            wide_keys = $urandom_range(0, 1);
            if ($urandom_range(0, 5) != 0)
                clear_table();
            count = $urandom_range(0, 12);
            append_run(count, wide_keys, $urandom_range(0, 7) != 0);
            repeat ($urandom_range(4, 10))
            begin
                case ($urandom_range(0, 19))
                    0:       issue(bst_pkg::MODE_NOP, $urandom);
                    1:       append_word(random_word(wide_keys));
                    default: search_random();
                endcase
            end
        end

        gappy     = 1'b1;
        wide_keys = 1'b1;
        clear_table();
        append_run(bst_pkg::DEF_TABLE_DEPTH, 1'b1, 1'b1);
        repeat (3) issue(bst_pkg::MODE_APPEND, $urandom);
        repeat (20) search_random();
        issue(bst_pkg::MODE_NOP, $urandom);

        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
